### hdl/rice_codec_with_zigzag_defines.svh
// Assertion macros for the Rice codec datapath.
// No dependencies; include by bare file name inside a module body.
`ifndef RICE_CODEC_WITH_ZIGZAG_DEFINES_SVH
`define RICE_CODEC_WITH_ZIGZAG_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RCZ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rcz_pkg.sv
// Shared types and constants for the Rice codec with zigzag map.
// No dependencies.
package rcz_pkg;

	localparam int VALUE_BITS    = 16;
	localparam int MAX_CODE_BITS = 64;
	localparam int M_BITS        = 4;
	localparam int ONES_BITS     = $clog2(MAX_CODE_BITS);
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 4;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_RICE_PARAM = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZIGZAG     = 1'd1;

	// Reset values of configuration
	localparam logic [M_BITS-1:0] RICE_PARAM_RESET = 4'd2;
	localparam logic              ZIGZAG_RESET     = 1'b1;

	// Item modes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [VALUE_BITS-1:0] value;
		logic                  code_bit;
	} item_t;

	typedef struct packed {
		logic                  bit_out;
		logic                  bit_valid;
		logic                  last;
		logic                  decoded_valid;
		logic [VALUE_BITS-1:0] decoded_value;
		logic                  overflow;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic enc_start;
		logic dec_step;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode;
		logic enc_ovf;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

### hdl/rice_codec_with_zigzag.sv
// Golomb-Rice codec with zigzag map: one value encoded to code bits, or one code bit decoded.
// Encode: the bit source loads at accept, then one code bit per cycle enters the result
//   register while it can take one; no new item is taken until the last code bit is emitted.
// Code too long, and every decode bit: done at the accept edge, which registers any result.
// Reset: m = 2, zigzag on, decoder at start of a codeword, result register empty.
module rice_codec_with_zigzag (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rcz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rcz_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  rcz_pkg::item_t                    item_data,
	output logic                              result_valid,
	input  logic                              result_ready,
	output rcz_pkg::result_t                  result_data
);
	import rcz_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence items
	rcz_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Compute codes and values
	rcz_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_data    (item_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

### hdl/rcz_ctrl.sv
// Controller for the Rice codec: accepts items and sequences code bit emission.
// Depends on rcz_pkg.
module rcz_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rcz_pkg::status_t status,
	output rcz_pkg::cmd_t    cmd
);
	import rcz_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	// Take an item only when the result slot can take its first result
	assign item_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept     = item_valid && item_ready;

	// Issue datapath commands
	always_comb begin
		cmd.enc_start = accept && (status.mode == MODE_ENCODE);
		cmd.dec_step  = accept && (status.mode == MODE_DECODE);
		cmd.emit      = (state_q == ST_EMIT) && status.out_free;
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.enc_start && !status.enc_ovf) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit && status.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/rcz_datapath.sv
// Datapath for the Rice codec: configuration, encoder bit source, decoder
// state and the result register. Depends on rcz_pkg and the defines header.
module rcz_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rcz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rcz_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  rcz_pkg::item_t                    item_data,
	input  rcz_pkg::cmd_t                     cmd,
	output rcz_pkg::status_t                  status,
	output logic                              result_valid,
	input  logic                              result_ready,
	output rcz_pkg::result_t                  result_data
);
	import rcz_pkg::*;
	`include "rice_codec_with_zigzag_defines.svh"

	localparam int FULL_BITS = VALUE_BITS + (1 << M_BITS) - 1;

	// Configuration
	logic [M_BITS-1:0] rice_m_q;
	logic              zigzag_q;

	// Encoder bit source
	logic [VALUE_BITS-1:0] enc_n_q;
	logic [ONES_BITS-1:0]  ones_q;
	logic                  zero_pend_q;
	logic [M_BITS-1:0]     rem_q;

	// Decoder state
	logic                    dec_phase_q;
	logic [VALUE_BITS-1:0]   qcount_q;
	logic [VALUE_BITS-2:0]   rshift_q;
	logic [M_BITS-1:0]       rcount_q;

	// Result register
	logic    out_valid_q;
	result_t out_q;

	// Encoder preparation
	logic [VALUE_BITS-1:0] enc_n;
	logic [VALUE_BITS-1:0] enc_q;
	logic [VALUE_BITS:0]   enc_len;
	logic                  enc_ovf;

	// Emission
	logic              emit_bit;
	logic              emit_last;
	logic [M_BITS-1:0] rem_idx;

	// Decode step
	logic [VALUE_BITS-1:0] dec_acc;
	logic [VALUE_BITS-1:0] dec_mmask;
	logic [M_BITS-1:0]     dec_cnt_next;
	logic                  dec_done;
	logic [VALUE_BITS-1:0] dec_r;
	logic [FULL_BITS-1:0]  dec_full;
	logic                  dec_ovf;
	logic [VALUE_BITS-1:0] dec_val;
	logic [VALUE_BITS-1:0] dec_unmapped;

	logic    load;
	result_t load_data;

	// Map value and split into quotient and code length
	always_comb begin
		if (zigzag_q) begin
			enc_n = {item_data.value[VALUE_BITS-2:0], 1'b0}
				^ {VALUE_BITS{item_data.value[VALUE_BITS-1]}};
		end else begin
			enc_n = item_data.value;
		end
		enc_q   = enc_n >> rice_m_q;
		enc_len = {1'b0, enc_q} + (VALUE_BITS+1)'(rice_m_q) + (VALUE_BITS+1)'(1);
		enc_ovf = enc_len > (VALUE_BITS+1)'(MAX_CODE_BITS);
	end

	// Select next code bit: unary ones, the stop zero, then remainder MSB first
	always_comb begin
		rem_idx = rem_q - M_BITS'(1);
		if (ones_q != '0) begin
			emit_bit  = 1'b1;
			emit_last = 1'b0;
		end else if (zero_pend_q) begin
			emit_bit  = 1'b0;
			emit_last = (rem_q == '0);
		end else begin
			emit_bit  = enc_n_q[rem_idx];
			emit_last = (rem_q == M_BITS'(1));
		end
	end

	// Advance decoder by one code bit and form the finished value
	always_comb begin
		dec_acc      = {rshift_q, item_data.code_bit};
		dec_mmask    = (VALUE_BITS'(1) << rice_m_q) - VALUE_BITS'(1);
		dec_cnt_next = rcount_q + M_BITS'(1);
		if (!dec_phase_q) begin
			dec_done = !item_data.code_bit && (rice_m_q == '0);
			dec_r    = '0;
		end else begin
			dec_done = (dec_cnt_next >= rice_m_q) || (dec_cnt_next == '0);
			dec_r    = dec_acc & dec_mmask;
		end
		dec_full     = (FULL_BITS'(qcount_q) << rice_m_q) | FULL_BITS'(dec_r);
		dec_ovf      = |dec_full[FULL_BITS-1:VALUE_BITS];
		dec_val      = dec_full[VALUE_BITS-1:0];
		dec_unmapped = {1'b0, dec_val[VALUE_BITS-1:1]} ^ {VALUE_BITS{dec_val[0]}};
	end

	// Choose what enters the result register
	always_comb begin
		load_data = '0;
		load      = 1'b0;
		if (cmd.enc_start && enc_ovf) begin
			load               = 1'b1;
			load_data.last     = 1'b1;
			load_data.overflow = 1'b1;
		end else if (cmd.emit) begin
			load                = 1'b1;
			load_data.bit_out   = emit_bit;
			load_data.bit_valid = 1'b1;
			load_data.last      = emit_last;
		end else if (cmd.dec_step && dec_done) begin
			load           = 1'b1;
			load_data.last = 1'b1;
			if (dec_ovf) begin
				load_data.overflow = 1'b1;
			end else begin
				load_data.decoded_valid = 1'b1;
				load_data.decoded_value = zigzag_q ? dec_unmapped : dec_val;
			end
		end
	end

	// Report status to the controller
	always_comb begin
		status.mode      = item_data.mode;
		status.enc_ovf   = enc_ovf;
		status.emit_last = emit_last;
		status.out_free  = !out_valid_q || result_ready;
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rice_m_q <= RICE_PARAM_RESET;
			zigzag_q <= ZIGZAG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RICE_PARAM: rice_m_q <= cfg_wdata[M_BITS-1:0];
				REG_ZIGZAG:     zigzag_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Load and drain the encoder bit source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q      <= '0;
			zero_pend_q <= 1'b0;
			rem_q       <= '0;
		end else if (cmd.enc_start && !enc_ovf) begin
			ones_q      <= enc_q[ONES_BITS-1:0];
			zero_pend_q <= 1'b1;
			rem_q       <= rice_m_q;
		end else if (cmd.emit) begin
			if (ones_q != '0) begin
				ones_q <= ones_q - ONES_BITS'(1);
			end else if (zero_pend_q) begin
				zero_pend_q <= 1'b0;
			end else begin
				rem_q <= rem_idx;
			end
		end
	end

	// Latch the mapped value for remainder bits
	always_ff @(posedge clk) begin
		if (cmd.enc_start) begin
			enc_n_q <= enc_n;
		end
	end

	// Update decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_phase_q <= 1'b0;
			qcount_q    <= '0;
			rshift_q    <= '0;
			rcount_q    <= '0;
		end else if (cmd.dec_step) begin
			if (dec_done) begin
				dec_phase_q <= 1'b0;
				qcount_q    <= '0;
				rshift_q    <= '0;
				rcount_q    <= '0;
			end else if (!dec_phase_q) begin
				if (item_data.code_bit) begin
					if (qcount_q != '1) begin
						qcount_q <= qcount_q + VALUE_BITS'(1);
					end
				end else begin
					dec_phase_q <= 1'b1;
					rshift_q    <= '0;
					rcount_q    <= '0;
				end
			end else begin
				rshift_q <= dec_acc[VALUE_BITS-2:0];
				rcount_q <= dec_cnt_next;
			end
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_data;
		end
	end

	`RCZ_ASSERT_NOW(a_no_clobber, load && out_valid_q, result_ready, "result overwritten before taken")
	`RCZ_ASSERT_NOW(a_ones_before_zero, ones_q != '0, zero_pend_q, "unary bits left without stop zero")
	`RCZ_ASSERT_NEXT(a_dec_restart, cmd.dec_step && dec_done, !dec_phase_q && (qcount_q == '0), "decoder not cleared after codeword")

endmodule

### test/tb.sv
// Self-checking bench for rice_codec_with_zigzag: encode and decode items with predicted results.
// Depends on rcz_pkg (item_t, result_t, register and mode codes) and the codec top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcz_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 42;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     item_valid = 1'b0;
	logic                     item_ready;
	item_t                    item_data = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	result_t                  result_data;

	rice_codec_with_zigzag dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	always #5 clk = ~clk;

	item_t   items_to_send[$];
	result_t coded_results_due[$];

	int   fails = 0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   queued = 0;
	int   idle_pct = 23;
	logic stall_arm = 1'b0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	// Codec state as the bench sees it
	logic [M_BITS-1:0] pred_m = RICE_PARAM_RESET;
	logic              pred_zz = ZIGZAG_RESET;
	logic              pred_in_rem = 1'b0;
	logic [15:0]       pred_ones = '0;
	logic [14:0]       pred_rem = '0;
	logic [3:0]        pred_rem_cnt = '0;

	function automatic result_t make_result(logic b, logic bv, logic lst, logic dv,
			logic [VALUE_BITS-1:0] dval, logic ovf);
		result_t r;
		r.bit_out       = b;
		r.bit_valid     = bv;
		r.last          = lst;
		r.decoded_valid = dv;
		r.decoded_value = dval;
		r.overflow      = ovf;
		return r;
	endfunction

	// Close the codeword: rebuild the value, reset the decoder, flag overflow or unmap if enabled
	task automatic close_codeword(input logic [14:0] r);
		logic [31:0] full;
		full = (32'(pred_ones) << pred_m) | 32'(r);
		pred_in_rem  = 1'b0;
		pred_ones    = '0;
		pred_rem     = '0;
		pred_rem_cnt = '0;
		if (full[31:16] != 16'd0) begin
			coded_results_due.push_back(make_result(1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b1));
		end else begin
			if (pred_zz)
				full[15:0] = {1'b0, full[15:1]} ^ {16{full[0]}};
			coded_results_due.push_back(make_result(1'b0, 1'b0, 1'b1, 1'b1, full[15:0], 1'b0));
		end
	endtask

	// Work out the results that one accepted item causes
	task automatic rice_predict(input item_t it);
		logic [15:0] n;
		logic [15:0] acc;
		logic [14:0] mmask;
		logic        b;
		int          qi;
		int          len;
		int          k;
		mmask = 15'((32'd1 << pred_m) - 32'd1);
		if (it.mode == MODE_ENCODE) begin
			n = it.value;
			if (pred_zz)
				n = {it.value[14:0], 1'b0} ^ {16{it.value[15]}};
			qi  = int'(n >> pred_m);
			len = qi + 1 + int'(pred_m);
			if (len > MAX_CODE_BITS) begin
				coded_results_due.push_back(make_result(1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b1));
			end else begin
				for (k = 0; k < len; k++) begin
					if (k < qi)
						b = 1'b1;
					else if (k == qi)
						b = 1'b0;
					else
						b = n[int'(pred_m) + qi - k];
					coded_results_due.push_back(make_result(b, 1'b1, k == len - 1, 1'b0, '0, 1'b0));
				end
			end
		end else if (!pred_in_rem) begin
			// Unary part: count ones, saturating; a zero ends it
			if (it.code_bit) begin
				if (pred_ones != 16'hFFFF)
					pred_ones = pred_ones + 16'd1;
			end else if (pred_m == 0) begin
				close_codeword(15'd0);
			end else begin
				pred_in_rem  = 1'b1;
				pred_rem     = '0;
				pred_rem_cnt = '0;
			end
		end else begin
			// Remainder part: shift in until the count reaches the current m
			acc          = {pred_rem, it.code_bit};
			pred_rem_cnt = pred_rem_cnt + 4'd1;
			if (pred_rem_cnt >= pred_m || pred_rem_cnt == 4'd0)
				close_codeword(acc[14:0] & mmask);
			else
				pred_rem = acc[14:0];
		end
	endtask

	// Driver: present queued items, hold each until accepted, gap at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_data  <= '0;
		end else begin
			if (item_valid && item_ready) begin
				rice_predict(item_data);
				items_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (items_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
					item_valid <= 1'b1;
					item_data  <= items_to_send.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [15:0] expv, logic [15:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0h, got %0h", name, expv, actv);
			fails++;
		end
	endfunction

	// Monitor: compare each result with the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (coded_results_due.size() == 0) begin
					$error("result with nothing predicted: %h", result_data);
					fails++;
				end else begin
					want = coded_results_due.pop_front();
					check_field("bit_out", 16'(want.bit_out), 16'(result_data.bit_out));
					check_field("bit_valid", 16'(want.bit_valid), 16'(result_data.bit_valid));
					check_field("last", 16'(want.last), 16'(result_data.last));
					check_field("decoded_valid", 16'(want.decoded_valid),
						16'(result_data.decoded_valid));
					check_field("decoded_value", want.decoded_value, result_data.decoded_value);
					check_field("overflow", 16'(want.overflow), 16'(result_data.overflow));
				end
				results_checked++;
			end
			// Long hold-off once armed, so the codec backs up into its input
			if (stall_arm && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_RICE_PARAM)
			pred_m = data;
		else
			pred_zz = data[0];
	endtask

	task automatic set_mode(input int m, input logic zz);
		write_reg(REG_RICE_PARAM, CFG_DATA_BITS'(m));
		// Upper data bits of the zigzag register are don't-care
		write_reg(REG_ZIGZAG, {3'($urandom_range(7)), zz});
	endtask

	task automatic push_encode(input logic [15:0] v);
		item_t it;
		it.mode     = MODE_ENCODE;
		it.value    = v;
		it.code_bit = 1'($urandom_range(1));
		items_to_send.push_back(it);
		queued++;
	endtask

	task automatic push_decode(input logic b);
		item_t it;
		it.mode     = MODE_DECODE;
		it.value    = 16'($urandom);
		it.code_bit = b;
		items_to_send.push_back(it);
		queued++;
	endtask

	// Send one codeword as code bits: q ones, a zero, m remainder bits MSB first
	task automatic push_codeword(input int q, input logic [14:0] r, input int m);
		int i;
		for (i = 0; i < q; i++)
			push_decode(1'b1);
		push_decode(1'b0);
		for (i = m - 1; i >= 0; i--)
			push_decode(r[i]);
	endtask

	// Pick a value whose code fits, mostly short, then undo the zigzag map if on
	function automatic logic [15:0] fitting_value(input int m, input logic zz);
		int          q;
		logic [31:0] n;
		q = ($urandom_range(9) == 0) ? $urandom_range(63 - m) : $urandom_range(6);
		n = (32'(q) << m) | ($urandom & ((32'd1 << m) - 32'd1));
		if (n > 32'hFFFF)
			n = n & 32'h7FFF;
		if (!zz)
			return n[15:0];
		return n[0] ? ~{1'b0, n[15:1]} : {1'b0, n[15:1]};
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || item_valid || coded_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(input int m, input logic zz, input int count);
		int start;
		int sel;
		int i;
		set_mode(m, zz);
		start = queued;
		while (queued - start < count) begin
			sel = $urandom_range(99);
			if (sel < 40) begin
				push_encode(fitting_value(m, zz));
			end else if (sel < 50) begin
				push_encode(16'($urandom));
			end else if (sel < 90) begin
				push_codeword(($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4),
					15'($urandom), m);
			end else begin
				for (i = $urandom_range(1, 5); i > 0; i--)
					push_decode(1'($urandom_range(1)));
			end
		end
	endtask

	// Hard limit on the whole run
	initial begin
		#8_000_000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		int phase_m [0:9];
		int phase_zz [0:9];
		int p;
		phase_m  = '{0, 15, 3, 1, 7, 15, 2, 5, 0, 10};
		phase_zz = '{1, 1, 0, 1, 0, 0, 1, 1, 0, 1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zigzag extremes, short code, too-long code
		set_mode(2, 1'b1);
		push_encode(16'h0000);
		push_encode(16'h8000);
		push_encode(16'hFFFF);
		push_encode(16'h7FFF);
		push_codeword(0, 15'd3, 2);
		wait_idle();

		// Widest remainder, zigzag off
		set_mode(15, 1'b0);
		push_encode(16'h0000);
		push_encode(16'hFFFF);
		push_encode(16'h5A5A);
		wait_idle();

		// No remainder: longest code that fits, one past it, bare zero codeword
		set_mode(0, 1'b0);
		push_encode(16'd63);
		push_encode(16'd64);
		push_codeword(0, 15'd0, 0);
		push_codeword(2, 15'd0, 0);
		wait_idle();

		// Leave a codeword inside its remainder, then shrink m under it
		set_mode(4, 1'b1);
		push_decode(1'b1);
		push_decode(1'b0);
		push_decode(1'b1);
		push_decode(1'b1);
		wait_idle();
		set_mode(1, 1'b1);
		push_decode(1'b1);
		wait_idle();

		// Random phases over a spread of settings
		for (p = 0; p < 10; p++) begin
			idle_pct = (p == 2) ? 0 : 23;
			run_random_phase(phase_m[p], 1'(phase_zz[p]), PHASE_ITEMS);
			if (p == 4)
				stall_arm = 1'b1;
			wait_idle();
		end
		idle_pct = 23;

		$display("tb: %0d items accepted, %0d results checked", items_accepted, results_checked);
		$display("tb: m from 0 to 15, zigzag on and off, overflows and a long output stall");
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
